// ----- hdl/phwu_pkg.sv -----
// Shared types and constants for the pixel hit word unpacker.
// Used by every module of the block; depends on nothing else.
package phwu_pkg;

  // Command codes of an input beat.
  localparam logic CMD_WORD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Widths of the fields and of the row store.
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned CHIP_W   = 3;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned HCNT_W   = 4;
  localparam int unsigned STORE_AW = CHIP_W + ROW_W;
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;

  // Epoch tag kept with each row word; a tag that differs from the
  // current epoch marks the entry as cleared.
  localparam int unsigned EPOCH_W = 10;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  // Bit positions inside a packet word.
  localparam int unsigned IDX_LSB     = 16;
  localparam int unsigned IDX_W       = 13;
  localparam int unsigned HIT_END_BIT = 29;
  localparam int unsigned SRC_PAR_BIT = 8;

  // Result queue depth and its count width.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PW    = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] word;
    logic              last_word;
    logic [CHIP_W-1:0] chip;
    logic [ROW_W-1:0]  row;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] row_word;
    logic              parity_done;
    logic              parity_ok;
    logic [HALF_W-1:0] computed_parity;
    logic [HALF_W-1:0] received_parity;
    logic              source_parity_flag;
  } out_t;

  // Request from the word decoder to the row store.
  typedef struct packed {
    logic                vld;
    logic                hit;
    logic                open;
    logic                close;
    logic [STORE_AW-1:0] addr;
    logic [WORD_W-1:0]   mask;
  } mem_req_t;

endpackage

// ----- hdl/phwu_word_ctrl.sv -----
// Word decoder: header counting, hit phase, index decoding and parity.
// Depends on phwu_pkg; drives row store requests and the parity fields.
module phwu_word_ctrl import phwu_pkg::*; #(
  parameter int unsigned HEADER_WORDS = 13
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_t      beat_i,
  output mem_req_t mem_req_o,
  output out_t     res_o
);

  localparam logic [HCNT_W-1:0] HDR_CNT = HCNT_W'(HEADER_WORDS);

  logic [HCNT_W-1:0] hc_q, hc_d, hc_e;
  logic              hit_ph_q, hit_ph_d, hit_ph_e;
  logic              odd_q, odd_d, odd_e;
  logic [HALF_W-1:0] acc_q, acc_d, acc_e;
  logic [HALF_W-1:0] prev_q, prev_d, prev_e;
  logic [HALF_W-1:0] prev2_q, prev2_d, prev2_e;
  logic [1:0]        seen_q, seen_d, seen_e;
  logic              open_q, open_d;
  logic              is_word, open_now, store_hit;
  logic [IDX_W-1:0]  idx;
  logic [HALF_W-1:0] low, inv_low, par;

  assign is_word  = accept_i && (beat_i.command == CMD_WORD);
  assign open_now = !open_q;
  assign idx      = beat_i.word[IDX_LSB +: IDX_W];
  assign low      = beat_i.word[HALF_W-1:0];
  assign inv_low  = ~low;

  // A word that arrives with no packet open starts from fresh state.
  always_comb begin
    hc_e     = open_now ? '0 : hc_q;
    hit_ph_e = open_now ? 1'b1 : hit_ph_q;
    odd_e    = open_now ? 1'b0 : odd_q;
    acc_e    = open_now ? '0 : acc_q;
    prev_e   = open_now ? '0 : prev_q;
    prev2_e  = open_now ? '0 : prev2_q;
    seen_e   = open_now ? '0 : seen_q;
  end

  // Header count, hit phase and the parity window.
  always_comb begin
    hc_d      = hc_e;
    hit_ph_d  = hit_ph_e;
    acc_d     = acc_e;
    seen_d    = seen_e;
    store_hit = 1'b0;
    if (hc_e < HDR_CNT) begin
      hc_d = hc_e + 1'b1;
    end else if (hit_ph_e) begin
      if (beat_i.word[HIT_END_BIT]) begin
        hit_ph_d = 1'b0;
      end else begin
        store_hit = 1'b1;
      end
    end
    if (seen_e[1]) begin
      acc_d = acc_e ^ prev2_e;
    end else begin
      seen_d = seen_e + 1'b1;
    end
    prev2_d = prev_e;
    prev_d  = low;
    odd_d   = !odd_e;
    open_d  = !beat_i.last_word;
  end

  // Parity is inverted when the word count is even.
  assign par = acc_d ^ {HALF_W{!odd_d}};

  always_comb begin
    res_o = '0;
    if (is_word && beat_i.last_word) begin
      res_o.parity_done        = 1'b1;
      res_o.parity_ok          = (par == prev2_d);
      res_o.computed_parity    = par;
      res_o.received_parity    = prev2_d;
      res_o.source_parity_flag = beat_i.word[SRC_PAR_BIT];
    end
  end

  // Index bit 12 set means an odd-chip row beyond the store: dropped.
  // Otherwise chip = {index[1:0], index[11]}, row = index[10:3].
  always_comb begin
    mem_req_o       = '0;
    mem_req_o.vld   = accept_i;
    mem_req_o.hit   = is_word && store_hit && !idx[IDX_W-1];
    mem_req_o.open  = is_word && open_now;
    mem_req_o.close = is_word && beat_i.last_word;
    if (beat_i.command == CMD_READ) begin
      mem_req_o.addr = {beat_i.chip, beat_i.row};
    end else begin
      mem_req_o.addr = {idx[1:0], idx[11], idx[10:3]};
    end
    if (idx[2]) begin
      mem_req_o.mask = {{HALF_W{1'b0}}, inv_low};
    end else begin
      mem_req_o.mask = {inv_low, {HALF_W{1'b0}}};
    end
  end

  // Packet state registers update on every accepted packet word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q     <= '0;
      hit_ph_q <= 1'b1;
      odd_q    <= 1'b0;
      acc_q    <= '0;
      prev_q   <= '0;
      prev2_q  <= '0;
      seen_q   <= '0;
      open_q   <= 1'b0;
    end else if (is_word) begin
      hc_q     <= hc_d;
      hit_ph_q <= hit_ph_d;
      odd_q    <= odd_d;
      acc_q    <= acc_d;
      prev_q   <= prev_d;
      prev2_q  <= prev2_d;
      seen_q   <= seen_d;
      open_q   <= open_d;
    end
  end

endmodule

// ----- hdl/phwu_row_store.sv -----
// Row store: tagged row word memory with read-modify-write and forwarding.
// Depends on phwu_pkg; serves requests from phwu_word_ctrl.
module phwu_row_store import phwu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_req_t          req_i,
  output logic [WORD_W-1:0] rd_word_o,
  output logic              busy_o
);

  typedef enum logic [1:0] {
    ST_INIT_CLR,
    ST_RUN,
    ST_WRAP_CLR
  } state_e;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [WORD_W-1:0]  data;
  } ent_t;

  ent_t row_mem [STORE_DEPTH];

  state_e              state_q;
  logic [STORE_AW-1:0] clr_ptr_q;
  logic [EPOCH_W-1:0]  epoch_q, item_tag;
  logic                busy;
  logic [STORE_AW-1:0] rd_addr;
  ent_t                rdata_q;

  logic                s1_hit_q, s1_pass_q, s1_zero_q;
  logic [STORE_AW-1:0] s1_addr_q;
  logic [WORD_W-1:0]   s1_mask_q;
  logic [EPOCH_W-1:0]  s1_tag_q;

  logic                wr_vld_q;
  logic [STORE_AW-1:0] wr_addr_q;
  ent_t                wr_ent_q;

  logic                fwd, wr_en;
  ent_t                raw, wr_ent;
  logic [WORD_W-1:0]   cur;

  assign busy     = (state_q != ST_RUN);
  assign busy_o   = busy;
  assign item_tag = req_i.open ? epoch_q + 1'b1 : epoch_q;
  assign rd_addr  = busy ? clr_ptr_q : req_i.addr;

  // Sweep state, sweep pointer and current epoch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT_CLR;
      clr_ptr_q <= '0;
      epoch_q   <= '0;
    end else begin
      case (state_q)
        ST_INIT_CLR, ST_WRAP_CLR: begin
          clr_ptr_q <= clr_ptr_q + 1'b1;
          if (clr_ptr_q == '1) begin
            state_q <= ST_RUN;
            epoch_q <= '0;
          end
        end
        ST_RUN: begin
          if (req_i.vld) begin
            epoch_q <= item_tag;
            if (req_i.close && (item_tag == EPOCH_MAX)) begin
              state_q   <= ST_WRAP_CLR;
              clr_ptr_q <= '0;
            end
          end
        end
        default: begin
          state_q <= ST_INIT_CLR;
        end
      endcase
    end
  end

  // Second stage control: an update, a sweep step, or neither.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_hit_q  <= 1'b0;
      s1_pass_q <= 1'b0;
      s1_zero_q <= 1'b0;
      wr_vld_q  <= 1'b0;
    end else begin
      s1_hit_q  <= !busy && req_i.vld && req_i.hit;
      s1_pass_q <= busy;
      s1_zero_q <= (state_q == ST_INIT_CLR);
      wr_vld_q  <= wr_en;
    end
  end

  // Second stage payload and the last write, kept for forwarding.
  always_ff @(posedge clk_i) begin
    s1_addr_q <= rd_addr;
    s1_mask_q <= req_i.mask;
    s1_tag_q  <= busy ? epoch_q : item_tag;
    wr_addr_q <= s1_addr_q;
    wr_ent_q  <= wr_ent;
  end

  // The write of the previous cycle is not yet visible in the read data.
  assign fwd = wr_vld_q && (wr_addr_q == s1_addr_q);
  assign raw = fwd ? wr_ent_q : rdata_q;
  assign cur = (raw.tag == s1_tag_q) ? raw.data : '0;
  assign rd_word_o = cur;

  // Hits OR their half in; a sweep retags live words to epoch zero.
  assign wr_en = s1_hit_q || s1_pass_q;
  always_comb begin
    wr_ent = '0;
    if (s1_pass_q) begin
      wr_ent.data = s1_zero_q ? '0 : cur;
    end else begin
      wr_ent.tag  = s1_tag_q;
      wr_ent.data = cur | s1_mask_q;
    end
  end

  // Simple dual-port memory: one read and one write each cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem[s1_addr_q] <= wr_ent;
    end
    rdata_q <= row_mem[rd_addr];
  end

  a_no_req_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !req_i.vld)
    else $error("row store request during a sweep");

  a_open_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.vld && req_i.open) |-> (epoch_q != EPOCH_MAX))
    else $error("packet opened with the epoch at its maximum");

  a_sweep_ends_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (epoch_q == '0))
    else $error("epoch not zero after a sweep");

endmodule

// ----- hdl/phwu_out_fifo.sv -----
// Result queue between the row store stage and the output channel.
// Depends on phwu_pkg for the result beat type and queue depth.
module phwu_out_fifo import phwu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  out_t              push_beat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_beat_o,
  output logic [OUT_CW-1:0] count_o
);

  out_t              slot_q [OUT_DEPTH];
  logic [OUT_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CW-1:0] cnt_q;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_beat_o  = slot_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign count_o     = cnt_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_beat_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |-> (cnt_q != OUT_CW'(OUT_DEPTH)))
    else $error("result queue overflow");

endmodule

// ----- hdl/pixel_hit_word_unpacker_with_parity_unit.sv -----
// Pixel hit word unpacker: one beat per clock while the input is not
// stalled. An accepted beat's result is registered while the row store is
// read, then enters the output queue. Packet words update the header, hit
// and parity state; hit words OR into a 2048-entry row store that holds one
// tagged 42-bit word per chip and row, read, modified and written back
// through one read port and one write port with forwarding of the previous
// write. Read beats return a stored row word. Each packet start bumps an
// epoch tag instead of clearing the store. The input stalls for a sweep of
// the store after reset and again after every 1023rd packet closes, when
// the epoch tags are renumbered; a four-entry result queue keeps input
// acceptance going while the output is stalled, until its slots are claimed.
module pixel_hit_word_unpacker_with_parity_unit import phwu_pkg::*; #(
  parameter int unsigned HEADER_WORDS = 13
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_beat_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_beat_o
);

  logic              accept, busy;
  mem_req_t          mem_req;
  out_t              res_s0, push_beat;
  logic [WORD_W-1:0] rd_word;
  logic [OUT_CW-1:0] fifo_cnt, inflight;

  logic s1_vld_q, s1_rd_q;
  out_t s1_res_q;

  // Accept only when every beat in flight has a queue slot waiting.
  assign inflight   = fifo_cnt + OUT_CW'(s1_vld_q);
  assign in_stall_o = busy || (inflight >= OUT_CW'(OUT_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  phwu_word_ctrl #(
    .HEADER_WORDS(HEADER_WORDS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_beat_i),
    .mem_req_o(mem_req),
    .res_o    (res_s0)
  );

  phwu_row_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_word_o(rd_word),
    .busy_o   (busy)
  );

  // Result fields are registered to line up with the row store read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q  <= (in_beat_i.command == CMD_READ);
      s1_res_q <= res_s0;
    end
  end

  always_comb begin
    push_beat          = s1_res_q;
    push_beat.row_word = s1_rd_q ? rd_word : '0;
  end

  phwu_out_fifo u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s1_vld_q),
    .push_beat_i(push_beat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o),
    .count_o    (fifo_cnt)
  );

endmodule
